[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[design/eyr_pkg.sv]
// Types, constants and fixed-point helpers for the Euler YXZ vector rotator.
`timescale 1ns / 1ps
package eyr_pkg;
  localparam int AngW = 20;
  localparam int VelW = 16;
  localparam int QuatW = 16;
  localparam int RotW = 25;
  localparam int TurnMdeg = 720000;
  localparam int QuadMdeg = 180000;
  localparam logic [23:0] PhaseK = 24'd9595049;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam int TabLen = 24;

  // one angle's CORDIC working values, Q30
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } lane_t;

  // item as it moves down the CORDIC chain; index 0 yaw, 1 pitch, 2 roll
  typedef struct packed {
    lane_t [2:0] lane;
    logic [2:0][1:0] quad;
    logic [2:0][VelW-1:0] vel;
  } cdc_item_t;

  // atan(2^-i) in Q30, rounded
  function automatic logic signed [31:0] atan_q30(input int i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd843314857;
      1: v = 32'sd497837829;
      2: v = 32'sd263043837;
      3: v = 32'sd133525159;
      4: v = 32'sd67021687;
      5: v = 32'sd33543516;
      6: v = 32'sd16775851;
      7: v = 32'sd8388437;
      8: v = 32'sd4194283;
      9: v = 32'sd2097149;
      10: v = 32'sd1048576;
      11: v = 32'sd524288;
      12: v = 32'sd262144;
      13: v = 32'sd131072;
      14: v = 32'sd65536;
      15: v = 32'sd32768;
      16: v = 32'sd16384;
      17: v = 32'sd8192;
      18: v = 32'sd4096;
      19: v = 32'sd2048;
      20: v = 32'sd1024;
      21: v = 32'sd512;
      22: v = 32'sd256;
      default: v = 32'sd128;
    endcase
    return v;
  endfunction

  // Q30 times Q30, rounded to Q30
  function automatic logic signed [32:0] mq(input logic signed [32:0] a,
                                            input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    p = p + (66'sd1 <<< 29);
    return p[62:30];
  endfunction
endpackage

[design/eyr_angle_front.sv]
// Angle reduction and radian conversion ahead of the CORDIC chain.
`timescale 1ns / 1ps
module eyr_angle_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2:0][eyr_pkg::AngW-1:0] ang,
  input  logic [2:0][eyr_pkg::VelW-1:0] vel,
  output logic out_valid,
  output eyr_pkg::cdc_item_t out_item
);
  logic v1;
  logic [2:0][1:0] quad1;
  logic [2:0][17:0] rem1;
  logic [2:0][eyr_pkg::VelW-1:0] vel1;
  logic [2:0][1:0] quad_c;
  logic [2:0][17:0] rem_c;
  eyr_pkg::cdc_item_t item_c;

  // fold into one turn, split into quadrant and remainder
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [19:0] r;
      logic [19:0] base;
      if (ang[k][eyr_pkg::AngW-1]) begin
        r = 20'(ang[k] + 20'(eyr_pkg::TurnMdeg));
      end else begin
        r = ang[k];
      end
      if (r >= 20'(3 * eyr_pkg::QuadMdeg)) begin
        quad_c[k] = 2'd3;
        base = 20'(3 * eyr_pkg::QuadMdeg);
      end else if (r >= 20'(2 * eyr_pkg::QuadMdeg)) begin
        quad_c[k] = 2'd2;
        base = 20'(2 * eyr_pkg::QuadMdeg);
      end else if (r >= 20'(eyr_pkg::QuadMdeg)) begin
        quad_c[k] = 2'd1;
        base = 20'(eyr_pkg::QuadMdeg);
      end else begin
        quad_c[k] = 2'd0;
        base = 20'd0;
      end
      rem_c[k] = 18'(r - base);
    end
  end

  // remainder to Q30 radians, seed the CORDIC
  always_comb begin
    item_c.quad = quad1;
    item_c.vel = vel1;
    for (int k = 0; k < 3; k++) begin
      logic [41:0] p;
      p = 42'(rem1[k]) * 42'(eyr_pkg::PhaseK) + 42'd512;
      item_c.lane[k].x = eyr_pkg::GainQ30;
      item_c.lane[k].y = 32'sd0;
      item_c.lane[k].z = $signed(p[41:10]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    if (en) begin
      quad1 <= quad_c;
      rem1 <= rem_c;
      vel1 <= vel;
      out_item <= item_c;
    end
  end
endmodule

[design/eyr_cordic_cell.sv]
// One rotation-mode CORDIC stage for all three angles.
`timescale 1ns / 1ps
module eyr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  eyr_pkg::cdc_item_t in_item,
  output logic out_valid,
  output eyr_pkg::cdc_item_t out_item
);
  localparam logic signed [31:0] Atan = eyr_pkg::atan_q30(STAGE);
  eyr_pkg::cdc_item_t item_c;

  // micro-rotation toward z = 0
  always_comb begin
    item_c = in_item;
    for (int k = 0; k < 3; k++) begin
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      dx = in_item.lane[k].y >>> STAGE;
      dy = in_item.lane[k].x >>> STAGE;
      if (!in_item.lane[k].z[31]) begin
        item_c.lane[k].x = in_item.lane[k].x - dx;
        item_c.lane[k].y = in_item.lane[k].y + dy;
        item_c.lane[k].z = in_item.lane[k].z - Atan;
      end else begin
        item_c.lane[k].x = in_item.lane[k].x + dx;
        item_c.lane[k].y = in_item.lane[k].y - dy;
        item_c.lane[k].z = in_item.lane[k].z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_item <= item_c;
    end
  end
endmodule

[design/eyr_rotator.sv]
// Quaternion build and vector rotation pipeline behind the CORDIC chain.
`timescale 1ns / 1ps
module eyr_rotator #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  eyr_pkg::cdc_item_t in_item,
  output logic out_valid,
  output logic [3:0][eyr_pkg::QuatW-1:0] quat,
  output logic [2:0][eyr_pkg::RotW-1:0] rot
);
  localparam int Sh = 30 - OUT_FRAC_BITS;
  localparam logic signed [52:0] RotMax = 53'sd16777215;
  localparam logic signed [52:0] RotMin = -53'sd16777216;

  logic [6:0] v;
  logic [2:0][eyr_pkg::VelW-1:0] vel0, vel1, vel2, vel3, vel4, vel5;
  logic signed [32:0] c0 [3];
  logic signed [32:0] s0 [3];
  logic signed [32:0] cy1, sy1, crsp1, srcp1, crcp1, srsp1;
  logic signed [32:0] t2 [8];
  logic signed [32:0] q3 [4];
  logic [3:0][eyr_pkg::QuatW-1:0] qo3, qo4, qo5, qo6;
  logic signed [32:0] ww4, xx4, yy4, zz4, xy4, xz4, yz4, wx4, wy4, wz4;
  logic signed [34:0] m5 [9];
  logic signed [50:0] p6 [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
      out_valid <= v[6];
    end
    if (en) begin
      // quadrant applied exactly
      for (int k = 0; k < 3; k++) begin
        logic signed [32:0] x;
        logic signed [32:0] y;
        x = 33'(in_item.lane[k].x);
        y = 33'(in_item.lane[k].y);
        case (in_item.quad[k])
          2'd0: begin c0[k] <= x; s0[k] <= y; end
          2'd1: begin c0[k] <= -y; s0[k] <= x; end
          2'd2: begin c0[k] <= -x; s0[k] <= -y; end
          default: begin c0[k] <= y; s0[k] <= -x; end
        endcase
      end
      vel0 <= in_item.vel;
      // roll-pitch pair products
      crsp1 <= eyr_pkg::mq(c0[2], s0[1]);
      srcp1 <= eyr_pkg::mq(s0[2], c0[1]);
      crcp1 <= eyr_pkg::mq(c0[2], c0[1]);
      srsp1 <= eyr_pkg::mq(s0[2], s0[1]);
      cy1 <= c0[0];
      sy1 <= s0[0];
      vel1 <= vel0;
      // times yaw terms
      t2[0] <= eyr_pkg::mq(crsp1, cy1);
      t2[1] <= eyr_pkg::mq(srcp1, sy1);
      t2[2] <= eyr_pkg::mq(crcp1, sy1);
      t2[3] <= eyr_pkg::mq(srsp1, cy1);
      t2[4] <= eyr_pkg::mq(srcp1, cy1);
      t2[5] <= eyr_pkg::mq(crsp1, sy1);
      t2[6] <= eyr_pkg::mq(crcp1, cy1);
      t2[7] <= eyr_pkg::mq(srsp1, sy1);
      vel2 <= vel1;
      // quaternion x, y, z, w and its Q15 output
      begin
        logic signed [32:0] qs [4];
        qs[0] = t2[0] + t2[1];
        qs[1] = t2[2] - t2[3];
        qs[2] = t2[4] - t2[5];
        qs[3] = t2[6] + t2[7];
        for (int k = 0; k < 4; k++) begin
          logic signed [32:0] r;
          q3[k] <= qs[k];
          r = (qs[k] + 33'sd16384) >>> 15;
          if (r > 33'sd32767) begin
            qo3[k] <= 16'h7fff;
          end else if (r < -33'sd32768) begin
            qo3[k] <= 16'h8000;
          end else begin
            qo3[k] <= r[15:0];
          end
        end
      end
      vel3 <= vel2;
      // second-order quaternion products
      ww4 <= eyr_pkg::mq(q3[3], q3[3]);
      xx4 <= eyr_pkg::mq(q3[0], q3[0]);
      yy4 <= eyr_pkg::mq(q3[1], q3[1]);
      zz4 <= eyr_pkg::mq(q3[2], q3[2]);
      xy4 <= eyr_pkg::mq(q3[0], q3[1]);
      xz4 <= eyr_pkg::mq(q3[0], q3[2]);
      yz4 <= eyr_pkg::mq(q3[1], q3[2]);
      wx4 <= eyr_pkg::mq(q3[3], q3[0]);
      wy4 <= eyr_pkg::mq(q3[3], q3[1]);
      wz4 <= eyr_pkg::mq(q3[3], q3[2]);
      qo4 <= qo3;
      vel4 <= vel3;
      // rotation matrix terms
      m5[0] <= 2 * (35'(ww4) + 35'(xx4)) - 35'sd1073741824;
      m5[1] <= 2 * (35'(xy4) - 35'(wz4));
      m5[2] <= 2 * (35'(xz4) + 35'(wy4));
      m5[3] <= 2 * (35'(xy4) + 35'(wz4));
      m5[4] <= 2 * (35'(ww4) + 35'(yy4)) - 35'sd1073741824;
      m5[5] <= 2 * (35'(yz4) - 35'(wx4));
      m5[6] <= 2 * (35'(xz4) - 35'(wy4));
      m5[7] <= 2 * (35'(yz4) + 35'(wx4));
      m5[8] <= 2 * (35'(ww4) + 35'(zz4)) - 35'sd1073741824;
      qo5 <= qo4;
      vel5 <= vel4;
      // matrix times vector
      for (int k = 0; k < 9; k++) begin
        p6[k] <= 51'(m5[k]) * 51'($signed(vel5[k % 3]));
      end
      qo6 <= qo5;
      // row sums, round and saturate
      for (int k = 0; k < 3; k++) begin
        logic signed [52:0] acc;
        logic signed [52:0] r;
        acc = 53'(p6[3 * k]) + 53'(p6[3 * k + 1]) + 53'(p6[3 * k + 2]);
        r = (acc + (53'sd1 <<< (Sh - 1))) >>> Sh;
        if (r > RotMax) begin
          rot[k] <= RotMax[eyr_pkg::RotW-1:0];
        end else if (r < RotMin) begin
          rot[k] <= RotMin[eyr_pkg::RotW-1:0];
        end else begin
          rot[k] <= r[eyr_pkg::RotW-1:0];
        end
      end
      quat <= qo6;
    end
  end
endmodule

[design/euler_yxz_rotate_vector.sv]
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: synchronous rst clears every stage's valid bit; payload is not reset.
// Depth is set by the angle front, the CORDIC cell chain and the multiplier stages behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_yxz_rotate_vector #(
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // yaw_mdeg, pitch_mdeg, roll_mdeg, vel_x, vel_y, vel_z, zero pad
  input  logic [111:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // quat_x, quat_y, quat_z, quat_w, rot_x, rot_y, rot_z, zero pad
  output logic [143:0] m_tdata
);
  logic en;
  logic cell_v [CORDIC_STAGES+1];
  eyr_pkg::cdc_item_t cell_item [CORDIC_STAGES+1];
  logic [2:0][eyr_pkg::AngW-1:0] ang;
  logic [2:0][eyr_pkg::VelW-1:0] vel;
  logic [3:0][eyr_pkg::QuatW-1:0] quat;
  logic [2:0][eyr_pkg::RotW-1:0] rot;

  // whole pipe moves unless a result is stuck at the output
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  assign ang[0] = s_tdata[19:0];
  assign ang[1] = s_tdata[39:20];
  assign ang[2] = s_tdata[59:40];
  assign vel[0] = s_tdata[75:60];
  assign vel[1] = s_tdata[91:76];
  assign vel[2] = s_tdata[107:92];

  eyr_angle_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .ang(ang), .vel(vel),
    .out_valid(cell_v[0]), .out_item(cell_item[0])
  );

  // CORDIC chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    eyr_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cell_v[i]), .in_item(cell_item[i]),
      .out_valid(cell_v[i+1]), .out_item(cell_item[i+1])
    );
  end

  eyr_rotator #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_rot (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cell_v[CORDIC_STAGES]), .in_item(cell_item[CORDIC_STAGES]),
    .out_valid(m_tvalid), .quat(quat), .rot(rot)
  );

  assign m_tdata = {5'd0, rot[2], rot[1], rot[0], quat[3], quat[2], quat[1], quat[0]};

  `ASSERT_CLK(a_ready_follows_out, s_tready == (!m_tvalid || m_tready))
  `ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid)
endmodule
